### hw/rtl/mpu_pkg.sv
package mpu_pkg;

  localparam int unsigned DataW = 64;
  localparam int unsigned StepCntW = $clog2(DataW);

  localparam logic KindMul = 1'b0;
  localparam logic KindPow = 1'b1;

  typedef logic [DataW-1:0] word_t;

  typedef struct packed {
    logic  start;
    word_t x;
    word_t y;
    word_t m;
  } mpu_req_t;

  typedef struct packed {
    logic  done;
    word_t res;
  } mpu_rsp_t;

endpackage

### hw/rtl/mpu_if.sv
interface mpu_in_if;
  logic              valid;
  logic              ready;
  logic              kind;
  mpu_pkg::word_t    operand_a;
  mpu_pkg::word_t    operand_b;
  mpu_pkg::word_t    modulus;

  modport source (output valid, output kind, output operand_a, output operand_b,
                  output modulus, input ready);
  modport sink (input valid, input kind, input operand_a, input operand_b,
                input modulus, output ready);
endinterface

interface mpu_out_if;
  logic              valid;
  logic              ready;
  mpu_pkg::word_t    result;
  logic              modulus_zero;

  modport source (output valid, output result, output modulus_zero, input ready);
  modport sink (input valid, input result, input modulus_zero, output ready);
endinterface

### hw/rtl/mpu_mulmod.sv
module mpu_mulmod (
  input  logic              clk,
  input  logic              rst_n,
  input  mpu_pkg::mpu_req_t req,
  output mpu_pkg::mpu_rsp_t rsp
);

  logic                            busy_r, busy_nxt;
  logic                            done_r, done_nxt;
  logic [mpu_pkg::StepCntW-1:0]    cnt_r, cnt_nxt;
  mpu_pkg::word_t                  acc_r, acc_nxt;
  mpu_pkg::word_t                  x_r, x_nxt;
  mpu_pkg::word_t                  y_r, y_nxt;
  mpu_pkg::word_t                  m_r, m_nxt;

  logic [mpu_pkg::DataW:0]         dbl, dbl_red, sum, sum_red;
  mpu_pkg::word_t                  acc_dbl, acc_step;

  // One step doubles the accumulator and adds x when the next multiplier bit is set,
  // reducing after each addition.
  always_comb begin
    dbl      = {acc_r, 1'b0};
    dbl_red  = dbl - {1'b0, m_r};
    acc_dbl  = dbl_red[mpu_pkg::DataW] ? dbl[mpu_pkg::DataW-1:0]
                                       : dbl_red[mpu_pkg::DataW-1:0];
    sum      = {1'b0, acc_dbl} + (y_r[mpu_pkg::DataW-1] ? {1'b0, x_r} : '0);
    sum_red  = sum - {1'b0, m_r};
    acc_step = sum_red[mpu_pkg::DataW] ? sum[mpu_pkg::DataW-1:0]
                                       : sum_red[mpu_pkg::DataW-1:0];
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    m_nxt    = m_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      acc_nxt  = '0;
      x_nxt    = req.x;
      y_nxt    = req.y;
      m_nxt    = req.m;
    end else if (busy_r) begin
      acc_nxt = acc_step;
      y_nxt   = {y_r[mpu_pkg::DataW-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == '1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    m_r   <= m_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.res  = acc_r;

endmodule

### hw/rtl/modular_power_u64.sv
// Computes (a*b) mod m for kind 0 and a^b mod m for kind 1 on 64-bit unsigned values, one
// item at a time; a zero modulus returns 0 with modulus_zero set. All arithmetic runs
// through one shared shift-and-add modular multiplier that retires one multiplier bit per
// cycle. Kind 0 takes two modular multiplications (reduce a, then multiply). Kind 1 takes
// one reduction plus, for every exponent bit up to the highest set bit, one squaring
// (except after the highest bit) and one multiplication for each set bit. A zero modulus
// skips the multiplier and goes straight to the finish state. The input is ready only
// while no item is in progress; a finished result waits in the output register, and the
// next item may be accepted while it waits.
module modular_power_u64 (
  input  logic     clk,
  input  logic     rst_n,
  mpu_in_if.sink   in_ch,
  mpu_out_if.source out_ch
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RED  = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_NEXT = 3'd3;
  localparam logic [2:0] ST_PMUL = 3'd4;
  localparam logic [2:0] ST_PSQ  = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  logic [2:0]          state_r, state_nxt;
  logic                kind_r, kind_nxt;
  mpu_pkg::word_t      b_r, b_nxt;
  mpu_pkg::word_t      m_r, m_nxt;
  mpu_pkg::word_t      acc_r, acc_nxt;
  mpu_pkg::word_t      sq_r, sq_nxt;
  mpu_pkg::word_t      res_r, res_nxt;
  logic                zero_r, zero_nxt;
  mpu_pkg::mpu_req_t   req_r, req_nxt;
  mpu_pkg::mpu_rsp_t   rsp;
  logic                out_valid_r, out_valid_nxt;
  mpu_pkg::word_t      out_result_r, out_result_nxt;
  logic                out_zero_r, out_zero_nxt;
  mpu_pkg::word_t      one_in, one_m;

  mpu_mulmod u_mulmod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req_r),
    .rsp   (rsp)
  );

  // The value 1 reduced by the modulus; it also serves as the multiplicand when an
  // operand is reduced by running it through the multiplier.
  assign one_in = (in_ch.modulus == mpu_pkg::word_t'(1)) ? '0 : mpu_pkg::word_t'(1);
  assign one_m  = (m_r == mpu_pkg::word_t'(1)) ? '0 : mpu_pkg::word_t'(1);

  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    b_nxt          = b_r;
    m_nxt          = m_r;
    acc_nxt        = acc_r;
    sq_nxt         = sq_r;
    res_nxt        = res_r;
    zero_nxt       = zero_r;
    req_nxt        = req_r;
    req_nxt.start  = 1'b0;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_result_nxt = out_result_r;
    out_zero_nxt   = out_zero_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          kind_nxt = in_ch.kind;
          b_nxt    = in_ch.operand_b;
          m_nxt    = in_ch.modulus;
          if (in_ch.modulus == '0) begin
            res_nxt   = '0;
            zero_nxt  = 1'b1;
            state_nxt = ST_FIN;
          end else begin
            zero_nxt      = 1'b0;
            req_nxt.start = 1'b1;
            req_nxt.x     = one_in;
            req_nxt.y     = in_ch.operand_a;
            req_nxt.m     = in_ch.modulus;
            state_nxt     = ST_RED;
          end
        end
      end
      ST_RED: begin
        if (rsp.done) begin
          sq_nxt = rsp.res;
          if (kind_r == mpu_pkg::KindMul) begin
            req_nxt.start = 1'b1;
            req_nxt.x     = rsp.res;
            req_nxt.y     = b_r;
            state_nxt     = ST_MUL;
          end else begin
            acc_nxt   = one_m;
            state_nxt = ST_NEXT;
          end
        end
      end
      ST_MUL: begin
        if (rsp.done) begin
          res_nxt   = rsp.res;
          state_nxt = ST_FIN;
        end
      end
      ST_NEXT: begin
        if (b_r == '0) begin
          res_nxt   = acc_r;
          state_nxt = ST_FIN;
        end else if (b_r[0]) begin
          req_nxt.start = 1'b1;
          req_nxt.x     = acc_r;
          req_nxt.y     = sq_r;
          state_nxt     = ST_PMUL;
        end else begin
          req_nxt.start = 1'b1;
          req_nxt.x     = sq_r;
          req_nxt.y     = sq_r;
          state_nxt     = ST_PSQ;
        end
      end
      ST_PMUL: begin
        if (rsp.done) begin
          acc_nxt   = rsp.res;
          b_nxt     = {b_r[mpu_pkg::DataW-1:1], 1'b0};
          state_nxt = ST_NEXT;
        end
      end
      ST_PSQ: begin
        if (rsp.done) begin
          sq_nxt    = rsp.res;
          b_nxt     = {1'b0, b_r[mpu_pkg::DataW-1:1]};
          state_nxt = ST_NEXT;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_result_nxt = res_r;
          out_zero_nxt   = zero_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      req_r.start   <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      req_r         <= req_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    b_r          <= b_nxt;
    m_r          <= m_nxt;
    acc_r        <= acc_nxt;
    sq_r         <= sq_nxt;
    res_r        <= res_nxt;
    zero_r       <= zero_nxt;
    out_result_r <= out_result_nxt;
    out_zero_r   <= out_zero_nxt;
  end

  assign in_ch.ready         = (state_r == ST_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.result       = out_result_r;
  assign out_ch.modulus_zero = out_zero_r;

endmodule

### hw/rtl/mpu_check.sv
module mpu_check (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input mpu_pkg::word_t out_result,
  input logic           out_modulus_zero
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result) && $stable(out_modulus_zero))
    else $error("result item changed or dropped while stalled");

  a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_modulus_zero |-> out_result == '0)
    else $error("zero modulus item carries a nonzero result");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready again right after an item was accepted");

endmodule

bind modular_power_u64 mpu_check u_mpu_check (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_result       (out_ch.result),
  .out_modulus_zero (out_ch.modulus_zero)
);
